// File: src/kle_pkg.sv
// Shared types and constants for the keyboard line editor.
`timescale 1ns / 1ps

package kle_pkg;

    localparam logic [7:0] KEY_BS = 8'h08;
    localparam logic [7:0] KEY_LF = 8'h0A;
    localparam logic [7:0] KEY_CR = 8'h0D;

    localparam int COUNT_W = 7;

    typedef enum logic [1:0] {
        KIND_ECHO      = 2'd0,
        KIND_BYTE      = 2'd1,
        KIND_NOT_READY = 2'd2,
        KIND_EMPTY     = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        CLS_PRINT     = 2'd0,
        CLS_BACKSPACE = 2'd1,
        CLS_ENTER     = 2'd2
    } key_class_t;

    // One classified input word as it travels from the front to the back.
    typedef struct packed {
        logic                 is_read;
        key_class_t           key_class;
        logic [7:0]           key;
        logic [COUNT_W-1:0]   max_bytes;
    } op_t;

endpackage

// File: src/kle_front.sv
// Front end: accepts input words, classifies them and queues them for the back end.
`timescale 1ns / 1ps

module kle_front #(
    parameter int LINE_SIZE = 64
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [15:0]      s_tdata,
    input  logic [0:0]       s_tuser,
    output logic             q_valid,
    output kle_pkg::op_t     q_op,
    input  logic             q_pop
);

    kle_pkg::op_t     op_in;
    kle_pkg::op_t     entry_reg [2];
    logic             wr_ptr_reg, wr_ptr_next;
    logic             rd_ptr_reg, rd_ptr_next;
    logic [1:0]       fill_reg, fill_next;
    logic             push;
    logic [7:0]       limit_m1;
    logic [7:0]       key;
    logic [7:0]       limit;

    assign key   = s_tdata[7:0];
    assign limit = s_tdata[15:8];

    always_comb begin
        op_in.is_read = s_tuser[0];
        op_in.key     = key;
        case (key) inside
            kle_pkg::KEY_LF, kle_pkg::KEY_CR: op_in.key_class = kle_pkg::CLS_ENTER;
            kle_pkg::KEY_BS:                  op_in.key_class = kle_pkg::CLS_BACKSPACE;
            default:                          op_in.key_class = kle_pkg::CLS_PRINT;
        endcase
        // A read returns at most limit-1 bytes and never more than the store holds.
        limit_m1 = (limit == 8'd0) ? 8'd0 : limit - 8'd1;
        if (limit_m1 > 8'(LINE_SIZE)) begin
            op_in.max_bytes = kle_pkg::COUNT_W'(LINE_SIZE);
        end else begin
            op_in.max_bytes = limit_m1[kle_pkg::COUNT_W-1:0];
        end
    end

    assign s_tready = (fill_reg != 2'd2);
    assign push     = s_tvalid && s_tready;
    assign q_valid  = (fill_reg != 2'd0);
    assign q_op     = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push) begin
            wr_ptr_next = ~wr_ptr_reg;
        end
        if (q_pop && q_valid) begin
            rd_ptr_next = ~rd_ptr_reg;
        end
        if (push && !(q_pop && q_valid)) begin
            fill_next = fill_reg + 2'd1;
        end else if (!push && q_pop && q_valid) begin
            fill_next = fill_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= op_in;
        end
    end

endmodule

// File: src/kle_back.sv
// Back end: edits the line store, drains finished lines and drives the result register.
`timescale 1ns / 1ps

module kle_back #(
    parameter int LINE_SIZE = 64
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             q_valid,
    input  kle_pkg::op_t     q_op,
    output logic             q_pop,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [15:0]      m_tdata,
    output logic [1:0]       m_tuser,
    output logic             m_tlast
);

    localparam int AW = $clog2(LINE_SIZE);
    localparam int CW = kle_pkg::COUNT_W;
    localparam logic [AW-1:0] NEAR_FULL = AW'(LINE_SIZE - 2);
    localparam logic [AW-1:0] TOP_ADDR  = AW'(LINE_SIZE - 1);

    typedef enum logic {
        ST_IDLE,
        ST_READ
    } state_t;

    state_t              state_reg, state_next;
    logic [AW-1:0]       cnt_reg, cnt_next;
    logic                ready_reg, ready_next;
    logic [AW-1:0]       rd_idx_reg, rd_idx_next;
    logic [CW-1:0]       rd_max_reg, rd_max_next;
    logic                out_valid_reg, out_valid_next;
    kle_pkg::kind_t      out_kind_reg, out_kind_next;
    logic [7:0]          out_data_reg, out_data_next;
    logic [CW-1:0]       out_count_reg, out_count_next;
    logic                out_last_reg, out_last_next;

    logic [7:0]          mem [LINE_SIZE];
    logic [LINE_SIZE-1:0] valid_reg;
    logic [7:0]          mem_q_reg;
    logic                vld_q_reg;

    logic                out_free;
    logic                near;
    logic                wr_en;
    logic [AW-1:0]       wr_addr;
    logic [7:0]          wr_data;
    logic                clr_en;
    logic [AW-1:0]       clr_addr;
    logic                clr_all;
    logic [AW-1:0]       rd_addr;
    logic [7:0]          rd_byte;
    logic [CW-1:0]       rd_count;
    logic                rd_last;

    assign out_free = !out_valid_reg || m_tready;
    assign near     = (cnt_reg >= NEAR_FULL);
    assign rd_byte  = vld_q_reg ? mem_q_reg : 8'd0;
    assign rd_count = CW'(rd_idx_reg) + CW'(1);
    assign rd_last  = (rd_byte == kle_pkg::KEY_LF) || (rd_count == rd_max_reg);

    always_comb begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        ready_next     = ready_reg;
        rd_idx_next    = rd_idx_reg;
        rd_max_next    = rd_max_reg;
        out_valid_next = out_valid_reg;
        out_kind_next  = out_kind_reg;
        out_data_next  = out_data_reg;
        out_count_next = out_count_reg;
        out_last_next  = out_last_reg;
        q_pop          = 1'b0;
        wr_en          = 1'b0;
        wr_addr        = cnt_reg;
        wr_data        = q_op.key;
        clr_en         = 1'b0;
        clr_addr       = TOP_ADDR;
        clr_all        = 1'b0;
        rd_addr        = '0;

        if (out_valid_reg && m_tready) begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (q_valid && out_free) begin
                    q_pop          = 1'b1;
                    out_kind_next  = kle_pkg::KIND_ECHO;
                    out_data_next  = q_op.key;
                    out_count_next = '0;
                    out_last_next  = 1'b1;
                    if (q_op.is_read) begin
                        out_data_next = 8'd0;
                        if (!ready_reg) begin
                            out_valid_next = 1'b1;
                            out_kind_next  = kle_pkg::KIND_NOT_READY;
                        end else if (q_op.max_bytes == '0) begin
                            out_valid_next = 1'b1;
                            out_kind_next  = kle_pkg::KIND_EMPTY;
                            clr_all        = 1'b1;
                            ready_next     = 1'b0;
                            cnt_next       = '0;
                        end else begin
                            state_next  = ST_READ;
                            rd_idx_next = '0;
                            rd_max_next = q_op.max_bytes;
                        end
                    end else begin
                        case (q_op.key_class)
                            kle_pkg::CLS_ENTER: begin
                                if (!ready_reg) begin
                                    wr_en          = 1'b1;
                                    wr_addr        = near ? NEAR_FULL : cnt_reg;
                                    wr_data        = kle_pkg::KEY_LF;
                                    ready_next     = 1'b1;
                                    cnt_next       = '0;
                                    out_valid_next = 1'b1;
                                end
                            end
                            kle_pkg::CLS_BACKSPACE: begin
                                // Near the end the top byte is cleared, not the last one typed.
                                if (near) begin
                                    clr_en         = 1'b1;
                                    clr_addr       = TOP_ADDR;
                                    cnt_next       = cnt_reg - AW'(1);
                                    out_valid_next = 1'b1;
                                end else if (cnt_reg != '0) begin
                                    clr_en         = 1'b1;
                                    clr_addr       = cnt_reg - AW'(1);
                                    cnt_next       = cnt_reg - AW'(1);
                                    out_valid_next = 1'b1;
                                end
                            end
                            default: begin
                                if (!near) begin
                                    wr_en          = 1'b1;
                                    wr_addr        = cnt_reg;
                                    cnt_next       = cnt_reg + AW'(1);
                                    out_valid_next = 1'b1;
                                end
                            end
                        endcase
                    end
                end
            end
            ST_READ: begin
                rd_addr = rd_idx_reg;
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_kind_next  = kle_pkg::KIND_BYTE;
                    out_data_next  = rd_byte;
                    out_count_next = rd_count;
                    out_last_next  = rd_last;
                    if (rd_last) begin
                        clr_all    = 1'b1;
                        ready_next = 1'b0;
                        cnt_next   = '0;
                        state_next = ST_IDLE;
                    end else begin
                        // Fetch the next byte now so one byte leaves per cycle while the result register is free.
                        rd_idx_next = rd_idx_reg + AW'(1);
                        rd_addr     = rd_idx_reg + AW'(1);
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            ready_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            ready_reg     <= ready_next;
            out_valid_reg <= out_valid_next;
        end
        rd_idx_reg    <= rd_idx_next;
        rd_max_reg    <= rd_max_next;
        out_kind_reg  <= out_kind_next;
        out_data_reg  <= out_data_next;
        out_count_reg <= out_count_next;
        out_last_reg  <= out_last_next;
    end

    // An entry whose valid bit is low reads as a cleared byte.
    always_ff @(posedge aclk) begin
        if (!aresetn || clr_all) begin
            valid_reg <= '0;
        end else begin
            if (wr_en) begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (clr_en) begin
                valid_reg[clr_addr] <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        mem_q_reg <= mem[rd_addr];
        vld_q_reg <= valid_reg[rd_addr];
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_count_reg, out_data_reg};
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;

endmodule

// File: src/keyboard_line_editor.sv
// Top level of the keyboard line editor: front end, queue and back end.
//
//  channel | direction | tdata (low bit first)         | tuser    | tlast
//  s_      | in        | key_char[7:0], read_limit[7:0]| command  | -
//  m_      | out       | data_byte[7:0], byte_count[6:0], pad | kind | last
//
// A key word's echo passes the queue and the result register, or is never given if ignored.
// A read word's first line byte passes the queue, the store's read register and the result
// register, then one byte per cycle while it is free, paced by the store's single read port.
// Reset clears the store at once through per-entry valid bits; no sweep.
// A stalled result register holds; the two-entry queue keeps taking words until it is full.
`timescale 1ns / 1ps

module keyboard_line_editor #(
    parameter int LINE_SIZE = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // key_char [7:0], read_limit [15:8]
    input  logic [0:0]  s_tuser,   // command [0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // data_byte [7:0], byte_count [14:8], zero [15]
    output logic [1:0]  m_tuser,   // kind [1:0]
    output logic        m_tlast
);

    logic          q_valid;
    logic          q_pop;
    kle_pkg::op_t  q_op;

    kle_front #(
        .LINE_SIZE(LINE_SIZE)
    ) u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .q_valid (q_valid),
        .q_op    (q_op),
        .q_pop   (q_pop)
    );

    kle_back #(
        .LINE_SIZE(LINE_SIZE)
    ) u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (q_valid),
        .q_op    (q_op),
        .q_pop   (q_pop),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .m_tlast (m_tlast)
    );

endmodule

// File: src/kle_checker.sv
// Port-level checks on the keyboard line editor and the bind that attaches them.
`timescale 1ns / 1ps

module kle_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic [1:0]  m_tuser
);

    logic is_byte;
    assign is_byte = (m_tuser == kle_pkg::KIND_BYTE);

    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result word changed");

    a_status_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !is_byte |-> m_tdata[15:8] == 8'd0)
        else $error("echo or status word carries a byte count");

    a_byte_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && is_byte |-> m_tdata[14:8] != 7'd0 && !m_tdata[15])
        else $error("line byte without a valid byte count");

    a_status_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == kle_pkg::KIND_NOT_READY || m_tuser == kle_pkg::KIND_EMPTY)
        |-> m_tdata[7:0] == 8'd0)
        else $error("status word carries data");

endmodule

bind keyboard_line_editor kle_checker u_kle_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser)
);
